FILE: hw/rtl/tl2s_pkg.sv
// tl2s_pkg: shared types and the seven-segment font for the temperature
// to lcd segment converter
// no dependencies
package tl2s_pkg;

  typedef logic [3:0] bcd_digit_t;

  // decimal digits of the magnitude plus the sign, thousands first
  typedef struct packed {
    logic       negative;
    bcd_digit_t thousands;
    bcd_digit_t hundreds;
    bcd_digit_t tens;
    bcd_digit_t units;
  } tl2s_digits_t;

  localparam int unsigned SegsPerByte = 8;

  // frame bit of the minus sign: first digit's G segment
  localparam int unsigned MinusBit = 5;

  // reciprocal multipliers for the constant divisions of a 16-bit magnitude
  localparam logic [15:0] RecipDiv10   = 16'd52429;  // shift 19
  localparam logic [12:0] RecipDiv100  = 13'd5243;   // shift 19
  localparam logic [15:0] RecipDiv1000 = 16'd33555;  // shift 25

  // font in segment order, bit 0 = A ... bit 6 = G
  function automatic logic [6:0] font_lookup(input bcd_digit_t digit);
    logic [6:0] pattern;
    unique case (digit)
      4'd0:    pattern = 7'h3F;
      4'd1:    pattern = 7'h06;
      4'd2:    pattern = 7'h5B;
      4'd3:    pattern = 7'h4F;
      4'd4:    pattern = 7'h66;
      4'd5:    pattern = 7'h6D;
      4'd6:    pattern = 7'h7D;
      4'd7:    pattern = 7'h07;
      4'd8:    pattern = 7'h7F;
      4'd9:    pattern = 7'h6F;
      default: pattern = 7'h00;
    endcase
    return pattern;
  endfunction

  // panel byte for one digit: A,B,C,D,E,F,G land on bits 3,2,1,0,4,6,5
  function automatic logic [SegsPerByte-1:0] panel_byte(input bcd_digit_t digit);
    logic [6:0]             pattern;
    logic [SegsPerByte-1:0] seg_byte;
    pattern     = font_lookup(digit);
    seg_byte    = '0;
    seg_byte[3] = pattern[0];
    seg_byte[2] = pattern[1];
    seg_byte[1] = pattern[2];
    seg_byte[0] = pattern[3];
    seg_byte[4] = pattern[4];
    seg_byte[6] = pattern[5];
    seg_byte[5] = pattern[6];
    return seg_byte;
  endfunction

  // remainder by ten of a quotient that stays below 40
  function automatic bcd_digit_t small_mod10(input logic [5:0] value);
    logic [5:0] rem;
    priority if (value >= 6'd30) begin
      rem = value - 6'd30;
    end else if (value >= 6'd20) begin
      rem = value - 6'd20;
    end else if (value >= 6'd10) begin
      rem = value - 6'd10;
    end else begin
      rem = value;
    end
    return rem[3:0];
  endfunction

endpackage

FILE: hw/rtl/temperature_to_lcd_segments.sv
// temperature_to_lcd_segments: top level, input and result registers around
// the digit split and frame build logic
// depends on tl2s_pkg, tl2s_digit_split, tl2s_frame_build
//
// Converts a signed temperature in tenths of a degree into the first four
// bytes of a segment LCD frame. A request is taken whenever start is high;
// busy stays low, so a new request can be issued every cycle. The frame for a
// request passes the input register and is loaded onto segment_word by the
// result register. It is held there for exactly one cycle with done high.
// Frames come out in request order. The receiver cannot stall, so it must
// capture segment_word on every cycle that done is high. Latency is set by
// the input register and the result register, with the digit split (three
// constant reciprocal multiplies) and the font lookup between them.
module temperature_to_lcd_segments (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] temp_tenths,
  output logic        done,
  output logic [31:0] segment_word
);
  import tl2s_pkg::*;

  logic         in_valid;
  logic [15:0]  in_temp;
  tl2s_digits_t digits;
  logic [31:0]  frame;

  // never stalls
  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_temp <= temp_tenths;
    end
  end

  tl2s_digit_split u_digit_split (
    .temp_tenths (in_temp),
    .digits      (digits)
  );

  tl2s_frame_build u_frame_build (
    .digits (digits),
    .frame  (frame)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      segment_word <= frame;
    end
  end

  // every request yields exactly one result, through the input and result registers
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> in_valid)
    else $error("request not captured in input register");

  assert property (@(posedge clk) disable iff (rst)
    in_valid |=> done)
    else $error("captured request did not produce a result");

  assert property (@(posedge clk) disable iff (rst)
    !in_valid |=> !done)
    else $error("result strobe without a request");

  // units digit always draws something
  assert property (@(posedge clk) disable iff (rst)
    done |-> segment_word[31:24] != 8'h00)
    else $error("units digit blank");

  // blank thousands digit of a positive value leaves byte 0 dark
  assert property (@(posedge clk) disable iff (rst)
    in_valid && digits.thousands == 4'd0 && !digits.negative
      |=> segment_word[7:0] == 8'h00)
    else $error("thousands digit not blanked");

endmodule

FILE: hw/rtl/tl2s_digit_split.sv
// tl2s_digit_split: takes the magnitude of a signed reading and splits it
// into four decimal digits (modulo 10000) with reciprocal multiplies
// depends on tl2s_pkg
module tl2s_digit_split (
  input  logic [15:0]           temp_tenths,
  output tl2s_pkg::tl2s_digits_t digits
);
  import tl2s_pkg::*;

  logic        negative;
  logic [15:0] mag;
  logic [31:0] prod10;
  logic [28:0] prod100;
  logic [31:0] prod1000;
  logic [11:0] q10;
  logic [8:0]  q100;
  logic [5:0]  q1000;
  logic [15:0] rem10;
  logic [11:0] rem100;
  logic [8:0]  rem1000;

  // magnitude, most negative code maps to 32768 in 16 bits
  assign negative = temp_tenths[15];
  assign mag      = negative ? 16'(~temp_tenths + 16'd1) : temp_tenths;

  // parallel quotients by 10, 100 and 1000
  assign prod10   = 32'(mag) * 32'(RecipDiv10);
  assign prod100  = 29'(mag) * 29'(RecipDiv100);
  assign prod1000 = 32'(mag) * 32'(RecipDiv1000);
  assign q10      = prod10[30:19];
  assign q100     = prod100[27:19];
  assign q1000    = prod1000[30:25];

  // each digit is the difference of neighboring quotients
  assign rem10   = mag  - 16'(q10)  * 16'd10;
  assign rem100  = q10  - 12'(q100) * 12'd10;
  assign rem1000 = q100 - 9'(q1000) * 9'd10;

  assign digits.negative  = negative;
  assign digits.thousands = small_mod10(q1000);
  assign digits.hundreds  = rem1000[3:0];
  assign digits.tens      = rem100[3:0];
  assign digits.units     = rem10[3:0];

endmodule

FILE: hw/rtl/tl2s_frame_build.sv
// tl2s_frame_build: encodes the digits with the segment font, blanks leading
// zeros and adds the minus sign to form the 32-bit segment frame
// depends on tl2s_pkg
module tl2s_frame_build (
  input  tl2s_pkg::tl2s_digits_t digits,
  output logic [31:0]            frame
);
  import tl2s_pkg::*;

  logic show_thousands;
  logic show_hundreds;
  logic [SegsPerByte-1:0] byte0;
  logic [SegsPerByte-1:0] byte1;
  logic [SegsPerByte-1:0] byte2;
  logic [SegsPerByte-1:0] byte3;

  // leading zero blanking on the two upper digits
  assign show_thousands = (digits.thousands != '0);
  assign show_hundreds  = show_thousands || (digits.hundreds != '0);

  always_comb begin
    byte0 = show_thousands ? panel_byte(digits.thousands) : '0;
    byte1 = show_hundreds  ? panel_byte(digits.hundreds)  : '0;
    byte2 = panel_byte(digits.tens);
    byte3 = panel_byte(digits.units);
    // minus sign ored over the first digit
    byte0[MinusBit] = byte0[MinusBit] | digits.negative;
  end

  assign frame = {byte3, byte2, byte1, byte0};

endmodule

FILE: dv/temperature_to_lcd_segments_test.sv
// temperature_to_lcd_segments_test: self-checking bench for the temperature to
// lcd segment frame converter, directed table then random requests
// depends on tl2s_pkg and temperature_to_lcd_segments
`timescale 1ns / 1ps

module temperature_to_lcd_segments_test;
  import tl2s_pkg::MinusBit;

  localparam int unsigned RandomRequests = 1100;
  localparam int unsigned QuietTail      = 150;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned DrainCycles    = 6;

  // one row of the directed table
  typedef struct {
    logic [15:0] temp;
    logic        typed;
    logic [31:0] frame;
  } temp_case_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] temp_tenths;
  logic        done;
  logic [31:0] segment_word;

  logic [31:0] frames_due[$];
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned requests_sent;
  int unsigned frames_checked;
  int unsigned negatives_sent;
  int unsigned blanked_sent;

  temp_case_t directed_cases[] = '{
    '{16'sd0,      1'b1, 32'h5F5F_0000},
    '{16'sd8888,   1'b1, 32'h7F7F_7F7F},
    '{-16'sd1,     1'b1, 32'h065F_0020},
    '{16'sd32767,  1'b1, 32'h0E7B_0E3D},
    '{-16'sd32767, 1'b1, 32'h0E7B_0E3D},
    '{16'h8000,    1'b1, 32'h7F7B_0E3D},
    '{16'sd1,      1'b0, 32'h0},
    '{16'sd9,      1'b0, 32'h0},
    '{16'sd10,     1'b0, 32'h0},
    '{16'sd99,     1'b0, 32'h0},
    '{16'sd100,    1'b0, 32'h0},
    '{16'sd999,    1'b0, 32'h0},
    '{16'sd1000,   1'b0, 32'h0},
    '{16'sd9999,   1'b0, 32'h0},
    '{16'sd10000,  1'b0, 32'h0},
    '{16'sd10009,  1'b0, 32'h0},
    '{-16'sd10,    1'b0, 32'h0},
    '{-16'sd100,   1'b0, 32'h0},
    '{-16'sd1000,  1'b0, 32'h0},
    '{16'sd1234,   1'b0, 32'h0},
    '{16'sd5678,   1'b0, 32'h0},
    '{16'sd9012,   1'b0, 32'h0},
    '{16'sd3456,   1'b0, 32'h0},
    '{16'sd7890,   1'b0, 32'h0},
    '{-16'sd605,   1'b0, 32'h0}
  };

  temperature_to_lcd_segments DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .temp_tenths  (temp_tenths),
    .done         (done),
    .segment_word (segment_word)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // panel byte of one decimal digit, segments A..G at bits 3,2,1,0,4,6,5
  function automatic logic [7:0] digit_panel_byte(input int unsigned digit);
    logic [6:0]      glyph;
    logic [6:0][2:0] seg_pos;
    logic [7:0]      pbyte;
    seg_pos = {3'd5, 3'd6, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3};
    case (digit)
      0:       glyph = 7'h3F;
      1:       glyph = 7'h06;
      2:       glyph = 7'h5B;
      3:       glyph = 7'h4F;
      4:       glyph = 7'h66;
      5:       glyph = 7'h6D;
      6:       glyph = 7'h7D;
      7:       glyph = 7'h07;
      8:       glyph = 7'h7F;
      default: glyph = 7'h6F;
    endcase
    pbyte = '0;
    for (int s = 0; s < 7; s++) begin
      if (glyph[s]) pbyte[seg_pos[s]] = 1'b1;
    end
    return pbyte;
  endfunction

  // full lcd frame for a raw 16-bit temperature
  function automatic logic [31:0] lcd_frame_of(input logic [15:0] raw);
    logic [16:0] mag17;
    int unsigned mag;
    int unsigned thou, hund, tens, units;
    logic [31:0] frame;
    mag17 = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    mag   = int'(mag17) % 10000;
    thou  = mag / 1000;
    hund  = (mag / 100) % 10;
    tens  = (mag / 10) % 10;
    units = mag % 10;
    frame = '0;
    if (thou != 0) frame[7:0] = digit_panel_byte(thou);
    if (thou != 0 || hund != 0) frame[15:8] = digit_panel_byte(hund);
    frame[23:16] = digit_panel_byte(tens);
    frame[31:24] = digit_panel_byte(units);
    if (raw[15]) frame[MinusBit] = 1'b1;
    return frame;
  endfunction

  // random temperature, weighted toward short magnitudes and digit edges
  function automatic logic [15:0] pick_temp();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
      4, 5, 6:    v = int'($urandom_range(0, 19998)) - 9999;
      7:          v = int'($urandom_range(0, 240)) - 120;
      8:          v = int'($urandom_range(0, 32)) * 1000 + int'($urandom_range(0, 2)) - 1;
      default:    v = int'($urandom_range(0, 3)) * 10000 + int'($urandom_range(0, 20)) - 10;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    if (v < 0 && $urandom_range(0, 3) == 0) v = -v;
    return v[15:0];
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // check every frame against the oldest one due; send_request records the requests
  always @(posedge clk) begin
    if (!rst && done) begin
      if (frames_due.size() == 0) begin
        $error("unexpected frame: segment_word actual %08h", segment_word);
        fail_count++;
      end else begin
        logic [31:0] due;
        due = frames_due.pop_front();
        frames_checked++;
        if (segment_word !== due) begin
          $error("segment_word mismatch: expected %08h actual %08h", due, segment_word);
          fail_count++;
        end
      end
    end
  end

  // one request, held until the block takes it
  task automatic send_request(input logic [15:0] raw, input logic typed,
                              input logic [31:0] frame);
    logic [31:0] model_frame;
    @(negedge clk);
    start       <= 1'b1;
    temp_tenths <= raw;
    @(posedge clk);
    while (busy) @(posedge clk);
    model_frame = lcd_frame_of(raw);
    frames_due.push_back(typed ? frame : model_frame);
    requests_sent++;
    if (raw[15]) negatives_sent++;
    if (model_frame[15:0] == 16'h0000 ||
        model_frame[15:0] == 16'h0020) blanked_sent++;
  endtask

  // sender goes quiet for the given number of cycles with noise on the data
  task automatic sender_idle(input int unsigned cycles);
    @(negedge clk);
    start       <= 1'b0;
    temp_tenths <= 16'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  initial begin
    int unsigned waited;
    rst            = 1'b1;
    start          = 1'b0;
    temp_tenths    = '0;
    cycle_count    = 0;
    fail_count     = 0;
    requests_sent  = 0;
    frames_checked = 0;
    negatives_sent = 0;
    blanked_sent   = 0;

    // hold synchronous reset, then release it at a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_cases[i]) begin
      send_request(directed_cases[i].temp, directed_cases[i].typed,
                   directed_cases[i].frame);
      if ($urandom_range(0, 3) == 0) sender_idle($urandom_range(1, 17));
    end

    // hold off until every directed frame is back
    @(negedge clk);
    start <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);

    // random requests, with no idle gaps in the last QuietTail of them
    for (int unsigned n = 0; n < RandomRequests; n++) begin
      send_request(pick_temp(), 1'b0, 32'h0);
      if (n < RandomRequests - QuietTail && $urandom_range(0, 7) == 0)
        sender_idle($urandom_range(1, 17));
    end
    @(negedge clk);
    start <= 1'b0;

    // drain
    waited = 0;
    while (frames_due.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (frames_due.size() != 0) begin
      $error("%0d frames never arrived", frames_due.size());
      fail_count++;
    end

    $display("%0d requests (%0d directed), %0d frames checked", requests_sent,
             directed_cases.size(), frames_checked);
    $display("%0d negative, %0d with both leading digits blanked", negatives_sent,
             blanked_sent);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
